/* rtl/m2a_pkg.sv */
// Package for the 2x2 matrix arithmetic unit: transaction types, command codes
// and pipeline depths. Used by every module of the block; depends on nothing.
package m2a_pkg;

   typedef logic signed [31:0] word_type;

   localparam logic [2:0] CMD_ADD = 3'd0;
   localparam logic [2:0] CMD_SUB = 3'd1;
   localparam logic [2:0] CMD_SCALE = 3'd2;
   localparam logic [2:0] CMD_DIV = 3'd3;
   localparam logic [2:0] CMD_MUL = 3'd4;

   localparam int FRAC_BITS = 16;
   localparam int QUO_BITS = 32 + FRAC_BITS;
   localparam int ARITH_LAT = 3;
   localparam int DIV_LAT = QUO_BITS + 2;
   localparam int ALIGN_LAT = DIV_LAT - ARITH_LAT;

   typedef struct packed {
      logic [2:0] command;
      word_type left_a;
      word_type left_b;
      word_type left_c;
      word_type left_d;
      word_type right_a;
      word_type right_b;
      word_type right_c;
      word_type right_d;
      word_type scalar;
   } req_type;

   typedef struct packed {
      word_type out_a;
      word_type out_b;
      word_type out_c;
      word_type out_d;
      logic overflow;
      logic divide_by_zero;
   } rsp_type;

   typedef struct packed {
      logic [3:0][31:0] val;
      logic ovf;
      logic dz;
   } lane_res_type;

endpackage

/* rtl/m2a_arith.sv */
// Add, subtract, scale and matrix product datapath: multiply, sum and
// saturate stages. Depends on m2a_pkg.
module m2a_arith (
   input  logic clock,
   input  logic reset,
   input  logic in_vld,
   input  m2a_pkg::req_type in_data,
   output logic out_vld,
   output m2a_pkg::lane_res_type out_res
);
   import m2a_pkg::*;

   typedef struct packed {
      logic ovf;
      logic [31:0] val;
   } sat_type;

   function automatic sat_type sat32(input logic signed [64:0] v);
      sat_type r;
      r.ovf = 1'b0;
      r.val = v[31:0];
      if (v > 65'sh0_7FFF_FFFF) begin
         r.ovf = 1'b1;
         r.val = 32'h7FFF_FFFF;
      end else if (v < -65'sh0_8000_0000) begin
         r.ovf = 1'b1;
         r.val = 32'h8000_0000;
      end
      return r;
   endfunction

   word_type l [4];
   word_type r [4];
   word_type ma [8];
   word_type mb [8];
   logic signed [63:0] prod_in [8];
   logic signed [63:0] prod_ff [8];
   word_type l_ff [4];
   word_type r_ff [4];
   logic [2:0] cmd1_ff;
   logic vld1_ff, vld2_ff, vld3_ff;
   logic signed [64:0] wide_in [4];
   logic signed [64:0] wide_ff [4];
   lane_res_type res_in, res_ff;

   assign l[0] = in_data.left_a;
   assign l[1] = in_data.left_b;
   assign l[2] = in_data.left_c;
   assign l[3] = in_data.left_d;
   assign r[0] = in_data.right_a;
   assign r[1] = in_data.right_b;
   assign r[2] = in_data.right_c;
   assign r[3] = in_data.right_d;

   always_comb begin
      for (int e = 0; e < 4; e++) begin
         if (in_data.command == CMD_SCALE) begin
            ma[2*e] = l[e];
            mb[2*e] = in_data.scalar;
            ma[2*e+1] = 32'sd0;
            mb[2*e+1] = 32'sd0;
         end else begin
            ma[2*e] = l[(e/2)*2];
            mb[2*e] = r[e%2];
            ma[2*e+1] = l[(e/2)*2+1];
            mb[2*e+1] = r[2+(e%2)];
         end
      end
      for (int m = 0; m < 8; m++) begin
         prod_in[m] = 64'(ma[m]) * 64'(mb[m]);
      end
   end

   always_comb begin
      logic signed [64:0] s;
      for (int e = 0; e < 4; e++) begin
         s = {prod_ff[2*e][63], prod_ff[2*e]} + {prod_ff[2*e+1][63], prod_ff[2*e+1]};
         unique case (cmd1_ff)
            CMD_ADD: wide_in[e] = {{33{l_ff[e][31]}}, l_ff[e]} + {{33{r_ff[e][31]}}, r_ff[e]};
            CMD_SUB: wide_in[e] = {{33{l_ff[e][31]}}, l_ff[e]} - {{33{r_ff[e][31]}}, r_ff[e]};
            CMD_SCALE, CMD_MUL: wide_in[e] = s >>> FRAC_BITS;
            default: wide_in[e] = 65'sd0;
         endcase
      end
   end

   always_comb begin
      sat_type t;
      res_in.ovf = 1'b0;
      res_in.dz = 1'b0;
      for (int e = 0; e < 4; e++) begin
         t = sat32(wide_ff[e]);
         res_in.val[e] = t.val;
         res_in.ovf = res_in.ovf | t.ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else begin
         vld1_ff <= in_vld;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
      end
      for (int m = 0; m < 8; m++) prod_ff[m] <= prod_in[m];
      for (int e = 0; e < 4; e++) begin
         l_ff[e] <= l[e];
         r_ff[e] <= r[e];
         wide_ff[e] <= wide_in[e];
      end
      cmd1_ff <= in_data.command;
      res_ff <= res_in;
   end

   assign out_vld = vld3_ff;
   assign out_res = res_ff;

endmodule

/* rtl/m2a_divider.sv */
// Pipelined restoring divider, four lanes sharing one divisor, one quotient
// bit per stage, with divide-by-zero and saturation handling. Depends on m2a_pkg.
module m2a_divider (
   input  logic clock,
   input  logic reset,
   input  logic in_vld,
   input  logic [3:0][31:0] num,
   input  logic [31:0] den,
   output logic out_vld,
   output m2a_pkg::lane_res_type out_res
);
   import m2a_pkg::*;

   logic vld_ff [QUO_BITS+1];
   logic [31:0] rem_ff [QUO_BITS+1][4];
   logic [QUO_BITS-1:0] dq_ff [QUO_BITS+1][4];
   logic [31:0] dmag_ff [QUO_BITS+1];
   logic nsign_ff [QUO_BITS+1][4];
   logic nzero_ff [QUO_BITS+1][4];
   logic dsign_ff [QUO_BITS+1];
   logic dz_ff [QUO_BITS+1];
   logic out_vld_ff;
   lane_res_type res_in, res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_vld;
      end
      dmag_ff[0] <= den[31] ? 32'(-den) : den;
      dsign_ff[0] <= den[31];
      dz_ff[0] <= (den == 32'd0);
      for (int e = 0; e < 4; e++) begin
         rem_ff[0][e] <= 32'd0;
         dq_ff[0][e] <= {(num[e][31] ? 32'(-num[e]) : num[e]), {FRAC_BITS{1'b0}}};
         nsign_ff[0][e] <= num[e][31];
         nzero_ff[0][e] <= (num[e] == 32'd0);
      end
   end

   for (genvar k = 1; k <= QUO_BITS; k++) begin : g_stage
      logic [31:0] rem_in [4];
      logic [QUO_BITS-1:0] dq_in [4];

      always_comb begin
         logic [32:0] t;
         logic ge;
         for (int e = 0; e < 4; e++) begin
            t = {rem_ff[k-1][e], dq_ff[k-1][e][QUO_BITS-1]};
            ge = (t >= {1'b0, dmag_ff[k-1]});
            rem_in[e] = ge ? 32'(t - {1'b0, dmag_ff[k-1]}) : t[31:0];
            dq_in[e] = {dq_ff[k-1][e][QUO_BITS-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_ff[k-1];
         end
         dmag_ff[k] <= dmag_ff[k-1];
         dsign_ff[k] <= dsign_ff[k-1];
         dz_ff[k] <= dz_ff[k-1];
         for (int e = 0; e < 4; e++) begin
            rem_ff[k][e] <= rem_in[e];
            dq_ff[k][e] <= dq_in[e];
            nsign_ff[k][e] <= nsign_ff[k-1][e];
            nzero_ff[k][e] <= nzero_ff[k-1][e];
         end
      end
   end

   always_comb begin
      logic [QUO_BITS-1:0] q;
      logic neg;
      res_in.ovf = 1'b0;
      res_in.dz = dz_ff[QUO_BITS];
      for (int e = 0; e < 4; e++) begin
         q = dq_ff[QUO_BITS][e];
         neg = nsign_ff[QUO_BITS][e] ^ dsign_ff[QUO_BITS];
         if (dz_ff[QUO_BITS]) begin
            if (nzero_ff[QUO_BITS][e]) begin
               res_in.val[e] = 32'd0;
            end else if (nsign_ff[QUO_BITS][e]) begin
               res_in.val[e] = 32'h8000_0000;
            end else begin
               res_in.val[e] = 32'h7FFF_FFFF;
            end
         end else if (!neg) begin
            if (q > QUO_BITS'(32'h7FFF_FFFF)) begin
               res_in.val[e] = 32'h7FFF_FFFF;
               res_in.ovf = 1'b1;
            end else begin
               res_in.val[e] = q[31:0];
            end
         end else begin
            if (q > QUO_BITS'(32'h8000_0000)) begin
               res_in.val[e] = 32'h8000_0000;
               res_in.ovf = 1'b1;
            end else begin
               res_in.val[e] = 32'(~q[31:0] + 32'd1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= vld_ff[QUO_BITS];
      end
      res_ff <= res_in;
   end

   assign out_vld = out_vld_ff;
   assign out_res = res_ff;

endmodule

/* rtl/matrix_2x2_arithmetic_unit.sv */
// Top level of the 2x2 matrix arithmetic unit: input register, arithmetic and
// divider pipelines, alignment and result register. Depends on m2a_pkg,
// m2a_arith and m2a_divider.
//
//   channel   ports                       transfer
//   request   start, busy, req_data       start high and busy low at a clock edge
//   response  rsp_strobe, rsp_data        one cycle per transaction, no stall
//
// A transaction enters every cycle; busy is always low. The result reaches the
// response ports through the input register, the 48-stage quotient pipeline of
// the divider and the result register; every command passes at equal depth.
// Reset empties the pipeline; transactions in flight are dropped.
module matrix_2x2_arithmetic_unit (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  m2a_pkg::req_type req_data,
   output logic rsp_strobe,
   output m2a_pkg::rsp_type rsp_data
);
   import m2a_pkg::*;

   logic req_vld_ff;
   req_type req_ff;
   lane_res_type arith_res, div_res;
   logic arith_vld;
   logic div_vld;
   lane_res_type align_ff [ALIGN_LAT];
   logic [2:0] cmd_ff [DIV_LAT];
   logic cmd_vld_ff [DIV_LAT];
   lane_res_type sel_res;
   logic rsp_strobe_ff;
   rsp_type rsp_data_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= start & ~busy;
      end
      req_ff <= req_data;
   end

   m2a_arith u_arith (
      .clock(clock),
      .reset(reset),
      .in_vld(req_vld_ff),
      .in_data(req_ff),
      .out_vld(arith_vld),
      .out_res(arith_res)
   );

   m2a_divider u_divider (
      .clock(clock),
      .reset(reset),
      .in_vld(req_vld_ff),
      .num({req_ff.left_d, req_ff.left_c, req_ff.left_b, req_ff.left_a}),
      .den(req_ff.scalar),
      .out_vld(div_vld),
      .out_res(div_res)
   );

   always_ff @(posedge clock) begin
      align_ff[0] <= arith_res;
      for (int i = 1; i < ALIGN_LAT; i++) align_ff[i] <= align_ff[i-1];
      cmd_ff[0] <= req_ff.command;
      for (int i = 1; i < DIV_LAT; i++) cmd_ff[i] <= cmd_ff[i-1];
      if (reset) begin
         for (int i = 0; i < DIV_LAT; i++) cmd_vld_ff[i] <= 1'b0;
      end else begin
         cmd_vld_ff[0] <= req_vld_ff;
         for (int i = 1; i < DIV_LAT; i++) cmd_vld_ff[i] <= cmd_vld_ff[i-1];
      end
   end

   assign sel_res = (cmd_ff[DIV_LAT-1] == CMD_DIV) ? div_res : align_ff[ALIGN_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= div_vld;
      end
      rsp_data_ff.out_a <= sel_res.val[0];
      rsp_data_ff.out_b <= sel_res.val[1];
      rsp_data_ff.out_c <= sel_res.val[2];
      rsp_data_ff.out_d <= sel_res.val[3];
      rsp_data_ff.overflow <= sel_res.ovf;
      rsp_data_ff.divide_by_zero <= sel_res.dz;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data = rsp_data_ff;

`ifndef ASSERT_OFF
   a_vld_align: assert property (@(posedge clock) disable iff (reset)
      div_vld == cmd_vld_ff[DIV_LAT-1])
      else $error("divider valid out of step with command line");

   a_arith_align: assert property (@(posedge clock) disable iff (reset)
      arith_vld == cmd_vld_ff[ARITH_LAT-1])
      else $error("arithmetic valid out of step with command line");

   a_dz_no_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.divide_by_zero |-> !rsp_data.overflow)
      else $error("divide by zero reported with overflow");

   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      div_vld && cmd_ff[DIV_LAT-1] != CMD_ADD && cmd_ff[DIV_LAT-1] != CMD_SUB &&
      cmd_ff[DIV_LAT-1] != CMD_SCALE && cmd_ff[DIV_LAT-1] != CMD_DIV &&
      cmd_ff[DIV_LAT-1] != CMD_MUL
      |=> rsp_data.out_a == 32'sd0 && rsp_data.out_b == 32'sd0 &&
          rsp_data.out_c == 32'sd0 && rsp_data.out_d == 32'sd0 && !rsp_data.overflow)
      else $error("unused command gave a nonzero result");
`endif

endmodule

/* tb/sv/matrix_2x2_checker.sv */
// Checker for the 2x2 matrix arithmetic unit: watches the request and response
// channels, predicts each result in Q16.16 and compares it field by field.
// Depends on m2a_pkg.
module matrix_2x2_checker (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic busy,
   input  m2a_pkg::req_type req_data,
   input  logic rsp_strobe,
   input  m2a_pkg::rsp_type rsp_data,
   output int fail_count,
   output int pending_count,
   output int result_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import m2a_pkg::*;

   rsp_type expected_results[$];

   function automatic logic signed [63:0] clamp_word(input logic signed [63:0] v,
                                                     inout logic ovf);
      if (v > 64'sd2147483647) begin
         ovf = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         ovf = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic rsp_type compute_matrix(input req_type r);
      rsp_type res;
      logic signed [63:0] lm[4], rm[4], sv, v[4];
      logic signed [127:0] acc;
      logic ovf;
      ovf = 1'b0;
      lm[0] = r.left_a; lm[1] = r.left_b; lm[2] = r.left_c; lm[3] = r.left_d;
      rm[0] = r.right_a; rm[1] = r.right_b; rm[2] = r.right_c; rm[3] = r.right_d;
      sv = r.scalar;
      for (int i = 0; i < 4; i++) v[i] = 0;
      res.divide_by_zero = 1'b0;
      case (r.command)
         CMD_ADD: for (int i = 0; i < 4; i++) v[i] = clamp_word(lm[i] + rm[i], ovf);
         CMD_SUB: for (int i = 0; i < 4; i++) v[i] = clamp_word(lm[i] - rm[i], ovf);
         CMD_SCALE: for (int i = 0; i < 4; i++) v[i] = clamp_word((lm[i] * sv) >>> 16, ovf);
         CMD_DIV: begin
            res.divide_by_zero = (sv == 0);
            for (int i = 0; i < 4; i++) begin
               if (sv == 0)
                  v[i] = lm[i] > 0 ? 64'sd2147483647 : (lm[i] < 0 ? -64'sd2147483648 : 0);
               else
                  v[i] = clamp_word((lm[i] * 64'sd65536) / sv, ovf);
            end
         end
         CMD_MUL: begin
            for (int i = 0; i < 4; i++) begin
               acc = 128'(lm[(i / 2) * 2] * rm[i % 2])
                   + 128'(lm[(i / 2) * 2 + 1] * rm[2 + i % 2]);
               acc = acc >>> 16;
               if (acc > 128'sd2147483647) begin
                  ovf = 1'b1;
                  v[i] = 64'sd2147483647;
               end else if (acc < -128'sd2147483648) begin
                  ovf = 1'b1;
                  v[i] = -64'sd2147483648;
               end else
                  v[i] = acc[63:0];
            end
         end
         default: ;
      endcase
      res.out_a = v[0][31:0];
      res.out_b = v[1][31:0];
      res.out_c = v[2][31:0];
      res.out_d = v[3][31:0];
      res.overflow = ovf;
      return res;
   endfunction

   assign pending_count = expected_results.size();

   initial begin
      fail_count = 0;
      result_count = 0;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (start && !busy) expected_results.push_back(compute_matrix(req_data));
         if (rsp_strobe) begin
            result_count++;
            if (expected_results.size() == 0) begin
               $error("unexpected result transaction");
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.out_a !== want.out_a) begin
                  $error("out_a expected %h actual %h", want.out_a, rsp_data.out_a);
                  fail_count++;
               end
               if (rsp_data.out_b !== want.out_b) begin
                  $error("out_b expected %h actual %h", want.out_b, rsp_data.out_b);
                  fail_count++;
               end
               if (rsp_data.out_c !== want.out_c) begin
                  $error("out_c expected %h actual %h", want.out_c, rsp_data.out_c);
                  fail_count++;
               end
               if (rsp_data.out_d !== want.out_d) begin
                  $error("out_d expected %h actual %h", want.out_d, rsp_data.out_d);
                  fail_count++;
               end
               if (rsp_data.overflow !== want.overflow) begin
                  $error("overflow expected %b actual %b", want.overflow, rsp_data.overflow);
                  fail_count++;
               end
               if (rsp_data.divide_by_zero !== want.divide_by_zero) begin
                  $error("divide_by_zero expected %b actual %b",
                         want.divide_by_zero, rsp_data.divide_by_zero);
                  fail_count++;
               end
            end
         end
      end
   end
endmodule

/* tb/sv/tb_matrix_2x2_arithmetic_unit.sv */
// Testbench top for the 2x2 matrix arithmetic unit: directed and random command
// transactions with random idle bursts. Depends on m2a_pkg, the block and
// matrix_2x2_checker.
module tb_matrix_2x2_arithmetic_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import m2a_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_strobe;
   rsp_type rsp_data;
   int fail_count, pending_count, result_count;

   matrix_2x2_arithmetic_unit dut (.*);
   matrix_2x2_checker checker_inst (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic word_type pick_word();
      case ($urandom_range(0, 7))
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         2: return 0;
         3: return word_type'($urandom_range(0, 1) ? 32'sh10000 : -32'sh10000);
         4: return word_type'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000);
         5: return word_type'($signed($urandom_range(0, 32'h1FFFFFF)) - 32'sh1000000);
         default: return word_type'($urandom());
      endcase
   endfunction

   function automatic req_type random_req();
      req_type r;
      r.command = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(0, 4));
      r.left_a = pick_word(); r.left_b = pick_word();
      r.left_c = pick_word(); r.left_d = pick_word();
      r.right_a = pick_word(); r.right_b = pick_word();
      r.right_c = pick_word(); r.right_d = pick_word();
      r.scalar = ($urandom_range(0, 9) == 0) ? 0 : pick_word();
      return r;
   endfunction

   task automatic send(input req_type r);
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_burst();
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clock);
   endtask

   initial begin
      req_type r;
      logic [2:0] cmd;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int k = 0; k < 24; k++) begin
         cmd = 3'(k % 8);
         r.command = cmd;
         if (k < 8) begin
            r.left_a = 32'sh7FFFFFFF; r.left_b = 32'sh80000000;
            r.left_c = 0; r.left_d = 32'sh10000;
            r.right_a = 32'sh7FFFFFFF; r.right_b = 32'sh80000000;
            r.right_c = 32'sh80000000; r.right_d = 32'sh7FFFFFFF;
            r.scalar = 0;
         end else if (k < 16) begin
            r.left_a = 32'sh80000000; r.left_b = 32'sh7FFFFFFF;
            r.left_c = -32'sh10000; r.left_d = 32'sh18000;
            r.right_a = 32'sh10000; r.right_b = 32'sh80000000;
            r.right_c = 32'sh7FFFFFFF; r.right_d = 32'sh7FFFFFFF;
            r.scalar = 32'sh80000000;
         end else begin
            r = random_req();
            r.command = cmd;
            r.scalar = (k % 2) ? 32'sh7FFFFFFF : -32'sh1;
         end
         send(r);
      end
      start <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      for (int k = 0; k < 650; k++) begin
         if (k < 580 && $urandom_range(0, 3) == 0) idle_burst();
         if (k == 300) begin
            start <= 1'b0;
            while (pending_count != 0) @(posedge clock);
         end
         send(random_req());
      end
      start <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (ALIGN_LAT + ARITH_LAT + 10) @(posedge clock);
      $display("Covered all commands, unused codes, divide by zero and saturating");
      $display("extremes; %0d results checked.", result_count);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      #2ms;
      $display("FAIL");
      $finish;
   end
endmodule
